[hw/rtl/irpw_pkg.sv]
package irpw_pkg;

	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int FRAME_BITS_W  = 6;
	localparam int HIGH_TIME_W   = 16;
	localparam int FRAME_WORD_W  = 32;
	localparam int S_TDATA_W     = 16;
	localparam int S_TUSER_W     = 2;
	localparam int M_TDATA_W     = 40;
	localparam int Q_DEPTH       = 2;
	localparam int Q_AW          = 1;
	localparam int DEF_WORD_BITS = 32;

	typedef enum logic [1:0] {
		OP_OVERFLOW = 2'd0,
		OP_RISE     = 2'd1,
		OP_FALL     = 2'd2,
		OP_READ     = 2'd3
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_MIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_MAX   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_BITS = 3'd6;

	localparam logic [CFG_W-1:0] RST_ONE_MIN  = 16'd150;
	localparam logic [CFG_W-1:0] RST_ONE_MAX  = 16'd600;
	localparam logic [CFG_W-1:0] RST_ZERO_MIN = 16'd800;
	localparam logic [CFG_W-1:0] RST_ZERO_MAX = 16'd2000;
	localparam logic [CFG_W-1:0] RST_HEAD_MIN = 16'd10000;
	localparam logic [CFG_W-1:0] RST_HEAD_MAX = 16'd15000;
	localparam logic [FRAME_BITS_W-1:0] RST_FRAME_BITS = 6'd20;

	typedef struct packed {
		logic [CFG_W-1:0] one_min;
		logic [CFG_W-1:0] one_max;
		logic [CFG_W-1:0] zero_min;
		logic [CFG_W-1:0] zero_max;
		logic [CFG_W-1:0] head_min;
		logic [CFG_W-1:0] head_max;
	} win_cfg_t;

	typedef struct packed {
		op_t  op;
		logic in_one;
		logic in_zero;
		logic in_head;
	} item_t;

endpackage

[hw/rtl/irpw_front.sv]
module irpw_front import irpw_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  win_cfg_t               cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  op_t                    op,
	input  logic [HIGH_TIME_W-1:0] high_time,
	output logic                   out_valid,
	input  logic                   out_ready,
	output item_t                  out_item
);

	logic  valid_s1;
	item_t item_s1;
	item_t item_c;

	assign in_ready = !valid_s1 || out_ready;

	always_comb begin
		item_c.op      = op;
		item_c.in_one  = (high_time > cfg.one_min) && (high_time < cfg.one_max);
		item_c.in_zero = (high_time > cfg.zero_min) && (high_time < cfg.zero_max);
		item_c.in_head = (high_time > cfg.head_min) && (high_time < cfg.head_max);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_c;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

[hw/rtl/irpw_queue.sv]
module irpw_queue import irpw_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_ready,
	output item_t out_item
);

	item_t           mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            push;
	logic            pop;

	assign in_ready  = (count_q != (Q_AW+1)'(Q_DEPTH));
	assign out_valid = (count_q != '0);
	assign out_item  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

[hw/rtl/irpw_back.sv]
module irpw_back import irpw_pkg::*; #(
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [FRAME_BITS_W-1:0] frame_bits,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  item_t                   in_item,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [FRAME_WORD_W-1:0] frame_word,
	output logic                    frame_pending,
	output logic                    receiving
);

	logic                    hdr_q, hdr_n;
	logic                    rise_q, rise_n;
	logic                    rdy_q, rdy_n;
	logic [WORD_BITS-1:0]    sw_q, sw_n;
	logic [FRAME_BITS_W-1:0] bc_q, bc_n;
	logic [WORD_BITS-1:0]    held_q, held_n;
	logic [WORD_BITS-1:0]    word_n;
	logic [FRAME_WORD_W-1:0] word_ext;
	logic [WORD_BITS-1:0]    shifted;
	logic [FRAME_BITS_W-1:0] cnt_inc;
	logic                    take;
	logic                    bit_v;
	logic                    pop;

	logic                    out_valid_q;
	logic [FRAME_WORD_W-1:0] word_q;
	logic                    pend_q;
	logic                    recv_q;

	assign in_ready = !out_valid_q || out_ready;
	assign pop      = in_valid && in_ready;

	always_comb begin
		hdr_n  = hdr_q;
		rise_n = rise_q;
		rdy_n  = rdy_q;
		sw_n   = sw_q;
		bc_n   = bc_q;
		held_n = held_q;
		word_n = '0;
		take   = 1'b0;
		bit_v  = 1'b0;
		unique case (in_item.op)
			OP_OVERFLOW: begin
				if (hdr_q) begin
					rise_n = 1'b0;
					bc_n   = '0;
					sw_n   = '0;
					hdr_n  = 1'b0;
				end
			end
			OP_READ: begin
				if (rdy_q) begin
					word_n = held_q;
					held_n = '0;
					rdy_n  = 1'b0;
				end
			end
			OP_RISE: begin
				if (!rdy_q) begin
					rise_n = 1'b1;
				end
			end
			OP_FALL: begin
				if (!rdy_q) begin
					if (rise_q) begin
						if (hdr_q) begin
							if (in_item.in_one) begin
								take  = 1'b1;
								bit_v = 1'b1;
							end else if (in_item.in_zero) begin
								take = 1'b1;
							end else if (in_item.in_head) begin
								bc_n = '0;
								sw_n = '0;
							end else begin
								bc_n  = '0;
								sw_n  = '0;
								hdr_n = 1'b0;
							end
						end else if (in_item.in_head) begin
							hdr_n = 1'b1;
							bc_n  = '0;
							sw_n  = '0;
						end
					end
					rise_n = 1'b0;
				end
			end
			default: ;
		endcase
		shifted = {sw_q[WORD_BITS-2:0], bit_v};
		cnt_inc = bc_q + 1'b1;
		if (take) begin
			sw_n = shifted;
			bc_n = cnt_inc;
			if (cnt_inc == frame_bits) begin
				held_n = shifted;
				sw_n   = '0;
				bc_n   = '0;
				hdr_n  = 1'b0;
				rdy_n  = 1'b1;
			end
		end
	end

	generate
		if (WORD_BITS >= FRAME_WORD_W) begin : g_wide
			assign word_ext = word_n[FRAME_WORD_W-1:0];
		end else begin : g_narrow
			assign word_ext = {{(FRAME_WORD_W-WORD_BITS){1'b0}}, word_n};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q       <= 1'b0;
			rise_q      <= 1'b0;
			rdy_q       <= 1'b0;
			sw_q        <= '0;
			bc_q        <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				hdr_q  <= hdr_n;
				rise_q <= rise_n;
				rdy_q  <= rdy_n;
				sw_q   <= sw_n;
				bc_q   <= bc_n;
				held_q <= held_n;
			end
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= word_ext;
			pend_q <= rdy_n;
			recv_q <= hdr_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_word    = word_q;
	assign frame_pending = pend_q;
	assign receiving     = recv_q;

endmodule

[hw/rtl/ir_pulse_width_frame_decoder_top.sv]
// Pulse-width remote frame decoder. Each input beat is one event: a timer
// overflow, a rising edge, a falling edge with its measured high time, or a
// read of the decoded frame; every beat gives exactly one output beat with
// the read word, the frame pending flag and the receiving flag. The block
// takes one beat per clock while m_tready does not hold the output. A beat
// passes the classify register, where the high time is compared against the
// three windows, then the two-entry queue, and then sits in the output
// register of the decode stage until it is taken. Window and frame length
// registers are to be written through the configuration port only while no
// beat is in flight; the block itself does not enforce this.
module ir_pulse_width_frame_decoder_top import irpw_pkg::*; #(
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// high_time[15:0]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// opcode[1:0]
	input  logic [S_TUSER_W-1:0] s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// frame_word[31:0], frame_pending[32], receiving[33], zero fill[39:34]
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	win_cfg_t                cfg_q;
	logic [FRAME_BITS_W-1:0] frame_bits_q;

	logic                    fq_valid;
	logic                    fq_ready;
	item_t                   fq_item;
	logic                    qb_valid;
	logic                    qb_ready;
	item_t                   qb_item;
	logic [FRAME_WORD_W-1:0] frame_word;
	logic                    frame_pending;
	logic                    receiving;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.one_min  <= RST_ONE_MIN;
			cfg_q.one_max  <= RST_ONE_MAX;
			cfg_q.zero_min <= RST_ZERO_MIN;
			cfg_q.zero_max <= RST_ZERO_MAX;
			cfg_q.head_min <= RST_HEAD_MIN;
			cfg_q.head_max <= RST_HEAD_MAX;
			frame_bits_q   <= RST_FRAME_BITS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ONE_MIN:    cfg_q.one_min  <= cfg_data;
				REG_ONE_MAX:    cfg_q.one_max  <= cfg_data;
				REG_ZERO_MIN:   cfg_q.zero_min <= cfg_data;
				REG_ZERO_MAX:   cfg_q.zero_max <= cfg_data;
				REG_HEAD_MIN:   cfg_q.head_min <= cfg_data;
				REG_HEAD_MAX:   cfg_q.head_max <= cfg_data;
				REG_FRAME_BITS: frame_bits_q   <= cfg_data[FRAME_BITS_W-1:0];
				default: ;
			endcase
		end
	end

	irpw_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op        (op_t'(s_tuser)),
		.high_time (s_tdata[HIGH_TIME_W-1:0]),
		.out_valid (fq_valid),
		.out_ready (fq_ready),
		.out_item  (fq_item)
	);

	irpw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fq_valid),
		.in_ready  (fq_ready),
		.in_item   (fq_item),
		.out_valid (qb_valid),
		.out_ready (qb_ready),
		.out_item  (qb_item)
	);

	irpw_back #(
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame_bits    (frame_bits_q),
		.in_valid      (qb_valid),
		.in_ready      (qb_ready),
		.in_item       (qb_item),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.frame_word    (frame_word),
		.frame_pending (frame_pending),
		.receiving     (receiving)
	);

	assign m_tdata = {{(M_TDATA_W-FRAME_WORD_W-2){1'b0}}, receiving, frame_pending, frame_word};

`ifndef ASSERT_OFF
	// A read that returns a word also clears the pending flag.
	a_word_clears_pending: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[FRAME_WORD_W-1:0] != '0) |-> !m_tdata[FRAME_WORD_W])
		else $error("nonzero frame word reported with frame still pending");

	// A completed frame drops reception, and edges are ignored while it waits.
	a_pending_not_receiving: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[FRAME_WORD_W] && m_tdata[FRAME_WORD_W+1]))
		else $error("frame pending and receiving reported together");
`endif

endmodule
